// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== src/bthalloc_pkg.sv =====
`default_nettype none
package bthalloc_pkg;

	localparam int HANDLE_W = 7;
	localparam int COUNT_W  = 7;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;

	localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_USED = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [HANDLE_W-1:0] handle_in;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  in_use_count;
	} rsp_t;

	typedef struct packed {
		logic               exists;
		logic               used;
		logic [COUNT_W-1:0] cnt;
	} node_t;

endpackage
`default_nettype wire

// ===== src/bthalloc_ram.sv =====
`default_nettype none
module bthalloc_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 63
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
	output logic      [WIDTH-1:0]                       rdata_a,
	output logic      [WIDTH-1:0]                       rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ===== src/balanced_tree_handle_allocator_core.sv =====
// Lookup checks the entry; an out-of-range handle is answered from idle. Free clears the entry
// and lowers each ancestor count to the root; allocate walks down, then raises counts back up.
// Throughput: one item at a time; busy falls with the result strobe, so the next item can be
// taken at the edge that ends it. Each level costs one registered RAM read, down and again up.
// Reset clears control, the per-entry valid flops and the root shadow; node storage itself
// is not swept, an entry never written reads as empty. The receiver cannot stall the block.
`default_nettype none
module balanced_tree_handle_allocator_core #(
	parameter int TREE_LEVELS = 6
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire bthalloc_pkg::req_t  req,
	output logic                     done,
	output bthalloc_pkg::rsp_t       rsp
);

	localparam int NODE_COUNT = (1 << TREE_LEVELS) - 1;
	localparam int AW = TREE_LEVELS;
	localparam int HW = bthalloc_pkg::HANDLE_W;
	localparam int CW = bthalloc_pkg::COUNT_W;
	localparam int NW = $bits(bthalloc_pkg::node_t);
	localparam logic [HW:0] NC_LIM = (HW+1)'(NODE_COUNT);
	localparam logic [AW:0] LEAF_FIRST = (AW+1)'((1 << (TREE_LEVELS - 1)) - 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ROOT  = 5'b00010,
		S_WALK  = 5'b00100,
		S_CHECK = 5'b01000,
		S_BUMP  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic [bthalloc_pkg::ACTION_W-1:0] act_q, act_d;
	logic [HW-1:0] hnd_q, hnd_d;
	logic [AW-1:0] cur_q, cur_d;
	logic          up_q, up_d;

	logic [NODE_COUNT-1:0] valid_q;
	logic vld_a_q, vld_b_q;
	logic root_ex_q;
	logic [CW-1:0] root_cnt_q;
	logic done_q;
	bthalloc_pkg::rsp_t rsp_q;

	logic [AW-1:0] raddr_a, raddr_b, waddr;
	logic          we;
	bthalloc_pkg::node_t wdata, node_a, node_b, nd;
	logic [NW-1:0] rdata_a, rdata_b;

	logic fin;
	logic [bthalloc_pkg::STATUS_W-1:0] fin_status;
	logic [HW-1:0] fin_handle;
	logic fin_ex;
	logic [CW-1:0] fin_cnt;
	logic [AW-1:0] nxt;

	function automatic logic is_leaf(input logic [AW-1:0] n);
		return {1'b0, n} >= LEAF_FIRST;
	endfunction

	function automatic logic [AW-1:0] left_of(input logic [AW-1:0] n);
		logic [AW:0] twice;
		twice = {n, 1'b0};
		return twice[AW-1:0] + 1'b1;
	endfunction

	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] n);
		return (n - 1'b1) >> 1;
	endfunction

	function automatic logic [CW-1:0] dec_sat(input logic [CW-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	bthalloc_ram #(
		.WIDTH (NW),
		.DEPTH (NODE_COUNT)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// An entry never written reads as an absent node.
	assign node_a = vld_a_q ? bthalloc_pkg::node_t'(rdata_a) : '0;
	assign node_b = vld_b_q ? bthalloc_pkg::node_t'(rdata_b) : '0;

	always_comb begin
		state_d    = state_q;
		act_d      = act_q;
		hnd_d      = hnd_q;
		cur_d      = cur_q;
		up_d       = up_q;
		raddr_a    = '0;
		raddr_b    = '0;
		we         = 1'b0;
		waddr      = '0;
		wdata      = '0;
		fin        = 1'b0;
		fin_status = bthalloc_pkg::ST_OK;
		fin_handle = hnd_q;
		nxt        = '0;
		nd         = node_a;
		unique case (state_q)
			S_IDLE: begin
				raddr_a = (req.action == bthalloc_pkg::ACT_ALLOC) ? '0 : req.handle_in[AW-1:0];
				if (start) begin
					act_d = req.action;
					hnd_d = req.handle_in;
					if (req.action == bthalloc_pkg::ACT_ALLOC) begin
						state_d = S_ROOT;
					end else if ({1'b0, req.handle_in} < NC_LIM) begin
						state_d = S_CHECK;
					end else begin
						fin        = 1'b1;
						fin_status = bthalloc_pkg::ST_NOT_USED;
						fin_handle = req.handle_in;
					end
				end
			end
			S_ROOT: begin
				if (!(node_a.exists && node_a.used)) begin
					we         = 1'b1;
					wdata      = '{exists: 1'b1, used: 1'b1, cnt: node_a.cnt + 1'b1};
					fin        = 1'b1;
					fin_handle = '0;
					state_d    = S_IDLE;
				end else if (is_leaf('0)) begin
					fin        = 1'b1;
					fin_status = bthalloc_pkg::ST_FULL;
					fin_handle = '0;
					state_d    = S_IDLE;
				end else begin
					raddr_a = left_of('0);
					raddr_b = left_of('0) + 1'b1;
					cur_d   = '0;
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				// missing left, then missing right, then smaller count; tie goes left
				if (!node_a.exists) begin
					nxt = left_of(cur_q);
					nd  = node_a;
				end else if (!node_b.exists) begin
					nxt = left_of(cur_q) + 1'b1;
					nd  = node_b;
				end else if (node_a.cnt <= node_b.cnt) begin
					nxt = left_of(cur_q);
					nd  = node_a;
				end else begin
					nxt = left_of(cur_q) + 1'b1;
					nd  = node_b;
				end
				if (!(nd.exists && nd.used)) begin
					we      = 1'b1;
					waddr   = nxt;
					wdata   = '{exists: 1'b1, used: 1'b1, cnt: nd.cnt + 1'b1};
					hnd_d   = HW'(nxt);
					raddr_a = cur_q;
					up_d    = 1'b1;
					state_d = S_BUMP;
				end else if (is_leaf(nxt)) begin
					fin        = 1'b1;
					fin_status = bthalloc_pkg::ST_FULL;
					fin_handle = '0;
					state_d    = S_IDLE;
				end else begin
					raddr_a = left_of(nxt);
					raddr_b = left_of(nxt) + 1'b1;
					cur_d   = nxt;
				end
			end
			S_CHECK: begin
				if (!node_a.used) begin
					fin        = 1'b1;
					fin_status = bthalloc_pkg::ST_NOT_USED;
					state_d    = S_IDLE;
				end else if (act_q == bthalloc_pkg::ACT_FREE) begin
					we    = 1'b1;
					waddr = hnd_q[AW-1:0];
					wdata = '{exists: node_a.exists, used: 1'b0, cnt: dec_sat(node_a.cnt)};
					if (hnd_q[AW-1:0] == '0) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						raddr_a = parent_of(hnd_q[AW-1:0]);
						cur_d   = parent_of(hnd_q[AW-1:0]);
						up_d    = 1'b0;
						state_d = S_BUMP;
					end
				end else begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_BUMP: begin
				we    = 1'b1;
				waddr = cur_q;
				wdata = '{exists: node_a.exists, used: node_a.used,
					cnt: up_q ? node_a.cnt + 1'b1 : dec_sat(node_a.cnt)};
				if (cur_q == '0) begin
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					raddr_a = parent_of(cur_q);
					cur_d   = parent_of(cur_q);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Root count after this beat, including a root write in the same cycle.
	assign fin_ex  = (we && waddr == '0) ? wdata.exists : root_ex_q;
	assign fin_cnt = (we && waddr == '0) ? wdata.cnt : root_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			valid_q    <= '0;
			vld_a_q    <= 1'b0;
			vld_b_q    <= 1'b0;
			root_ex_q  <= 1'b0;
			root_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_a_q <= valid_q[raddr_a];
			vld_b_q <= valid_q[raddr_b];
			if (we) begin
				valid_q[waddr] <= 1'b1;
				if (waddr == '0) begin
					root_ex_q  <= wdata.exists;
					root_cnt_q <= wdata.cnt;
				end
			end
			done_q <= fin;
		end
	end

	always_ff @(posedge clk) begin
		act_q <= act_d;
		hnd_q <= hnd_d;
		cur_q <= cur_d;
		up_q  <= up_d;
		if (fin) begin
			rsp_q.handle_out   <= fin_handle;
			rsp_q.status       <= fin_status;
			rsp_q.in_use_count <= fin_ex ? fin_cnt : '0;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

// ===== src/bthalloc_chk.sv =====
`default_nettype none
`include "assert_macros.svh"
module bthalloc_chk (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire bthalloc_pkg::rsp_t rsp
);

	logic accept;
	logic full_beat;
	logic full_ok;
	logic known_status;
	assign accept    = start && !busy;
	assign full_beat = done && (rsp.status == bthalloc_pkg::ST_FULL);
	assign full_ok   = (rsp.handle_out == '0) && (rsp.in_use_count != '0);
	assign known_status = (rsp.status == bthalloc_pkg::ST_OK) ||
		(rsp.status == bthalloc_pkg::ST_FULL) || (rsp.status == bthalloc_pkg::ST_NOT_USED);

	// an accepted beat either keeps the block working or answers at once
	`CHK_ASSERT(a_accept_progress, clk, arst_n, accept |=> (busy || done), "accepted beat lost")
	// a result only follows work or an accepted beat
	`CHK_ASSERT(a_done_cause, clk, arst_n, done |-> $past(busy || start), "result out of nowhere")
	`CHK_ASSERT(a_full_handle, clk, arst_n, full_beat |-> full_ok, "bad full result")
	`CHK_NEVER(a_status_code, clk, arst_n, done && !known_status, "undefined status code")

endmodule

bind balanced_tree_handle_allocator_core bthalloc_chk u_chk (.*);
`default_nettype wire

// ===== sim/balanced_tree_handle_allocator_core_test.sv =====
`default_nettype none
module balanced_tree_handle_allocator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bthalloc_pkg::*;

	localparam int TREE_LEVELS = 6;
	localparam int NODES = (1 << TREE_LEVELS) - 1;
	localparam logic [ACTION_W-1:0] ACT_UNDEF = 2'd3;
	localparam int REPORT_LIMIT = 10;

	class handle_tree_scoreboard;
		bit                 node_exists [NODES];
		bit                 node_used [NODES];
		logic [COUNT_W-1:0] subtree_count [NODES];
		rsp_t               awaited_results [$];
		int                 mismatch_count;

		function new();
			for (int i = 0; i < NODES; i++) begin
				node_exists[i] = 1'b0;
				node_used[i] = 1'b0;
				subtree_count[i] = '0;
			end
			mismatch_count = 0;
		endfunction

		function int pending();
			return awaited_results.size();
		endfunction

		// Walk from a node to the root, adjusting every count on the way.
		function void adjust_path(int unsigned n, bit up);
			forever begin
				if (up)
					subtree_count[n] = subtree_count[n] + 1'b1;
				else if (subtree_count[n] != '0)
					subtree_count[n] = subtree_count[n] - 1'b1;
				if (n == 0)
					break;
				n = (n - 1) >> 1;
			end
		endfunction

		function rsp_t apply_request(req_t r);
			rsp_t        o;
			int unsigned n;
			int unsigned left;
			int unsigned right;
			int unsigned h;
			bit          full;
			o.handle_out = r.handle_in;
			o.status = ST_OK;
			h = 32'(r.handle_in);
			if (r.action == ACT_ALLOC) begin
				n = 0;
				full = 1'b0;
				while (node_exists[n] && node_used[n]) begin
					left = 2 * n + 1;
					right = 2 * n + 2;
					if (right >= NODES) begin
						full = 1'b1;
						break;
					end
					if (!node_exists[left])
						n = left;
					else if (!node_exists[right])
						n = right;
					else if (subtree_count[left] <= subtree_count[right])
						n = left;
					else
						n = right;
				end
				if (full) begin
					o.status = ST_FULL;
					o.handle_out = '0;
				end else begin
					node_exists[n] = 1'b1;
					node_used[n] = 1'b1;
					adjust_path(n, 1'b1);
					o.handle_out = n[HANDLE_W-1:0];
				end
			end else if (h >= NODES) begin
				o.status = ST_NOT_USED;
			end else if (!node_used[h]) begin
				o.status = ST_NOT_USED;
			end else if (r.action == ACT_FREE) begin
				node_used[h] = 1'b0;
				adjust_path(h, 1'b0);
			end
			o.in_use_count = node_exists[0] ? subtree_count[0] : '0;
			return o;
		endfunction

		function void note_request(req_t r);
			awaited_results.push_back(apply_request(r));
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result beat: handle %0d status %0d count %0d",
						got.handle_out, got.status, got.in_use_count);
				return;
			end
			want = awaited_results.pop_front();
			if (got.handle_out !== want.handle_out || got.status !== want.status ||
					got.in_use_count !== want.in_use_count) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("mismatch: handle %0d/%0d status %0d/%0d count %0d/%0d (exp/act)",
						want.handle_out, got.handle_out, want.status, got.status,
						want.in_use_count, got.in_use_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	bit in_reset = 1'b1;
	int idle_pct = 0;
	handle_tree_scoreboard sb = new();

	balanced_tree_handle_allocator_core #(
		.TREE_LEVELS(TREE_LEVELS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!in_reset) begin
			if (start && busy === 1'b0)
				sb.note_request(req);
			if (done === 1'b1)
				sb.check_response(rsp);
		end
	end

	// Hold start high until a beat is taken; idle cycles drop it first.
	task automatic issue(input req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy !== 1'b0);
	endtask

	task automatic issue_op(input logic [ACTION_W-1:0] act, input int unsigned h);
		req_t r;
		r.action = act;
		r.handle_in = h[HANDLE_W-1:0];
		issue(r);
	endtask

	// Frees and lookups mostly target live handles so the tree empties as well as fills.
	function automatic req_t next_request(int alloc_pct, int free_pct);
		req_t        r;
		int unsigned roll;
		int unsigned live [$];
		roll = $urandom_range(99);
		r.handle_in = HANDLE_W'($urandom_range(127));
		if (roll < alloc_pct)
			r.action = ACT_ALLOC;
		else if (roll < alloc_pct + free_pct)
			r.action = ACT_FREE;
		else if (roll < 96)
			r.action = ACT_LOOKUP;
		else
			r.action = ACT_UNDEF;
		if (r.action != ACT_ALLOC && $urandom_range(99) < 75) begin
			for (int i = 0; i < NODES; i++)
				if (sb.node_used[i])
					live.push_back(i);
			if (live.size() != 0)
				r.handle_in = HANDLE_W'(live[$urandom_range(live.size() - 1)]);
		end
		return r;
	endfunction

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int sender_idle [4];
		int drain_cycles;
		sender_idle = '{0, 46, 0, 25};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		in_reset = 1'b0;
		@(posedge clk);

		// empty tree, out-of-range handle, unknown action
		issue_op(ACT_LOOKUP, 0);
		issue_op(ACT_FREE, 0);
		issue_op(ACT_LOOKUP, 127);
		issue_op(ACT_UNDEF, 0);
		repeat (5) issue_op(ACT_ALLOC, $urandom_range(127));
		issue_op(ACT_LOOKUP, 3);
		issue_op(ACT_UNDEF, 5);
		issue_op(ACT_FREE, 1);
		issue_op(ACT_FREE, 1);
		// node 1 still exists with a live child, so it is reused
		issue_op(ACT_ALLOC, 127);
		issue_op(ACT_FREE, 0);
		issue_op(ACT_ALLOC, 0);
		issue_op(ACT_FREE, 62);
		issue_op(ACT_LOOKUP, 63);
		issue_op(ACT_FREE, 127);
		issue_op(ACT_LOOKUP, 62);
		issue_op(ACT_UNDEF, 127);

		foreach (sender_idle[p]) begin
			idle_pct = sender_idle[p];
			// fill past full, drain to empty, then a mixed stretch
			repeat (130) issue(next_request(80, 8));
			repeat (130) issue(next_request(10, 70));
			repeat (150) issue(next_request(45, 35));
		end
		start <= 1'b0;

		for (drain_cycles = 0; sb.pending() != 0 && drain_cycles < 2000; drain_cycles++)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (sb.pending() != 0)
			$display("results never returned: %0d", sb.pending());
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
